[sv/edfi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Package for the edge defect frame inspector.
// Word types, register indexes, verdict codes and the frame size check.
// No dependencies.
package edfi_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_PIXELS    = 65536;

  localparam int FIELD_W    = 17;
  localparam int LEVEL_W    = 8;
  localparam int ROW_W      = 16;
  localparam int TALLY_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LEVEL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFECT_LIMIT = 2'd3;

  localparam logic [FIELD_W-1:0] WIDTH_RST  = 17'd256;
  localparam logic [FIELD_W-1:0] HEIGHT_RST = 17'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_RST  = 8'd64;
  localparam logic [FIELD_W-1:0] LIMIT_RST  = 17'd0;

  // Verdict codes
  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_FAIL  = 2'd1;
  localparam logic [1:0] VERDICT_SMALL = 2'd2;
  localparam logic [1:0] VERDICT_LARGE = 2'd3;

  // Luma weights and the reciprocal for the divide by nine
  localparam logic [15:0] LUMA_R     = 16'd77;
  localparam logic [15:0] LUMA_G     = 16'd150;
  localparam logic [15:0] LUMA_B     = 16'd29;
  localparam logic [24:0] BLUR_RECIP = 25'd7282;
  localparam logic [7:0]  PIX_MAX    = 8'd255;

  typedef struct packed {
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic [TALLY_W-1:0] defect_total;
  } out_word_t;

  // Small frames are checked first, then width and pixel count.
  function automatic logic [1:0] frame_check(input logic [FIELD_W-1:0] w,
                                             input logic [FIELD_W-1:0] h,
                                             input logic [FIELD_W-1:0] max_w);
    logic [33:0] area;
    area = 34'(w) * 34'(h);
    if (w < 17'd3 || h < 17'd3) begin
      return VERDICT_SMALL;
    end else if (w > max_w || area > 34'(MAX_PIXELS)) begin
      return VERDICT_LARGE;
    end
    return VERDICT_PASS;
  endfunction

endpackage
`default_nettype wire

[sv/edge_defect_frame_inspector.sv]
`timescale 1ns / 1ps
`default_nettype none
// Edge defect frame inspector: luma, 3x3 box blur, Sobel and defect count.
// Depends on edfi_pkg.
//
// RGB pixels enter in raster order, one word per cycle, and the block gives one word per
// frame: a verdict and the number of edge pixels whose Sobel magnitude (on the blurred
// luma plane, clamped to 255) exceeds edge_level. Border pixels of the blurred plane carry
// luma straight through and border edge pixels never count. Within a frame a pixel is
// taken every cycle; two line stores of MAX_WIDTH words (luma rows, blurred rows) hold the
// two previous rows of each plane, each read into a register and written back by the stage using it.
// After the last pixel of a frame the input closes (gap, flush and drain states) while the
// bottom row is read back out of the luma store and run through the Sobel stage; the
// result word then appears and input reopens. The last pixel is only taken while the
// output register is free. If the frame is under 3 by 3, wider than MAX_WIDTH or holds
// more than MAX_PIXELS pixels, every pixel is dropped and answered with an error word, one
// per cycle while the output side keeps up. Any register write restarts the frame; a write
// waits until no pixel is left in the pipeline. There is no clearing pass: stale
// line-store entries are never used for a result.
module edge_defect_frame_inspector #(
  parameter int MAX_WIDTH = edfi_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  edfi_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output edfi_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [edfi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [edfi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import edfi_pkg::*;

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [1:0] {ST_RUN, ST_GAP, ST_FLUSH, ST_DRAIN} state_t;

  // Registers
  state_t               state_r;
  logic [FIELD_W-1:0]   frame_width_r, frame_height_r, defect_limit_r;
  logic [LEVEL_W-1:0]   edge_level_r;
  logic [1:0]           err_r;
  logic [ColW-1:0]      col_r, fx_r;
  logic [ROW_W-1:0]     row_r;
  logic [TALLY_W-1:0]   tally_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  // Config next values; the size check is taken from them so a word may follow at once
  logic                 cfg_fire;
  logic [FIELD_W-1:0]   width_nxt, height_nxt, limit_nxt;
  logic [LEVEL_W-1:0]   level_nxt;
  logic [1:0]           err_nxt;

  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    width_nxt  = frame_width_r;
    height_nxt = frame_height_r;
    level_nxt  = edge_level_r;
    limit_nxt  = defect_limit_r;
    if (cfg_fire) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = cfg_data;
        CFG_FRAME_HEIGHT: height_nxt = cfg_data;
        CFG_EDGE_LEVEL:   level_nxt  = cfg_data[LEVEL_W-1:0];
        CFG_DEFECT_LIMIT: limit_nxt  = cfg_data;
        default: ;
      endcase
    end
    err_nxt = frame_check(width_nxt, height_nxt, FIELD_W'(MAX_WIDTH));
  end

  // Input side
  logic last_col, last_row, needs_slot, slot_free;
  logic in_fire, pix_fire, err_fire, frame_done;
  logic [15:0] luma_full;
  logic [7:0]  luma_g;

  assign last_col   = (FIELD_W'(col_r) + 17'd1) == frame_width_r;
  assign last_row   = (FIELD_W'(row_r) + 17'd1) == frame_height_r;
  assign needs_slot = (err_r != VERDICT_PASS) || (last_col && last_row);
  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_RUN) && (!needs_slot || slot_free);
  assign in_fire    = in_valid && in_ready;
  assign pix_fire   = in_fire && (err_r == VERDICT_PASS);
  assign err_fire   = in_fire && (err_r != VERDICT_PASS);
  assign frame_done = pix_fire && last_col && last_row;

  assign luma_full = LUMA_R * 16'(in_data.red_value) + LUMA_G * 16'(in_data.green_value)
                   + LUMA_B * 16'(in_data.blue_value);
  assign luma_g    = luma_full[15:8];

  // Luma line store: each word holds {row r-2, row r-1} of one column
  logic [15:0]     luma_mem [MAX_WIDTH];
  logic [15:0]     luma_rd_r;
  logic [ColW-1:0] luma_ra;
  logic            fx_last;

  assign luma_ra = (state_r == ST_FLUSH) ? fx_r : col_r;
  assign fx_last = (FIELD_W'(fx_r) + 17'd1) == frame_width_r;

  // Stage 1: luma word with its two rows above
  logic            s1_v_r, s1_fl_r;
  logic [7:0]      s1_g_r;
  logic [ColW-1:0] s1_c_r;
  logic            s1_rge1_r, s1_q0_r, s1_qge2_r, s1_lastcol_r, s1_last_r;
  logic [7:0]      lw_r [3][2];
  logic [7:0]      l_old, l_new;
  logic [7:0]      lcol [3];
  logic [11:0]     sum9;
  logic            e1, border1;

  assign l_old   = luma_rd_r[15:8];
  assign l_new   = luma_rd_r[7:0];
  assign lcol[0] = l_old;
  assign lcol[1] = l_new;
  assign lcol[2] = s1_g_r;

  always_comb begin
    sum9 = '0;
    for (int k = 0; k < 3; k++) begin
      sum9 = sum9 + 12'(lw_r[k][0]) + 12'(lw_r[k][1]) + 12'(lcol[k]);
    end
  end

  // Blurred pixel one column back; the right border pixel follows in the next cycle
  assign e1      = s1_v_r && s1_rge1_r && (s1_c_r != '0);
  assign border1 = s1_q0_r || (s1_c_r == ColW'(1));

  always_ff @(posedge clk) begin
    luma_rd_r <= luma_mem[luma_ra];
    if (s1_v_r) begin
      luma_mem[s1_c_r] <= {l_new, s1_g_r};
      for (int k = 0; k < 3; k++) begin
        lw_r[k][0] <= lw_r[k][1];
        lw_r[k][1] <= lcol[k];
      end
    end
  end

  logic            e2_pend_r;
  logic [ColW-1:0] e2_x_r;
  logic [7:0]      e2_val_r;
  logic            e2_qge2_r;

  // Stage 2: divide by nine
  logic            s2_v_r, s2_border_r, s2_qge2_r, s2_last_r;
  logic [ColW-1:0] s2_x_r;
  logic [7:0]      s2_val_r;
  logic [11:0]     s2_sum_r;
  logic [24:0]     blur_prod;
  logic [7:0]      blur_b;

  assign blur_prod = 25'(s2_sum_r) * BLUR_RECIP;
  assign blur_b    = s2_border_r ? s2_val_r : blur_prod[23:16];

  // Blurred line store: {row q-2, row q-1}
  logic [15:0] blur_mem [MAX_WIDTH];
  logic [15:0] blur_rd_r;

  // Stage 3: Sobel
  logic            s3_v_r, s3_qge2_r, s3_last_r;
  logic [ColW-1:0] s3_x_r;
  logic [7:0]      s3_b_r;
  logic [7:0]      bw_r [3][2];
  logic [7:0]      bcol [3];
  logic [11:0]     gx_pos, gx_neg, gy_pos, gy_neg;
  logic [9:0]      agx, agy;
  logic [10:0]     mag;
  logic [7:0]      mag_clamp;

  assign bcol[0] = blur_rd_r[15:8];
  assign bcol[1] = blur_rd_r[7:0];
  assign bcol[2] = s3_b_r;

  always_comb begin
    gx_pos = 12'(bcol[0]) + {3'b0, bcol[1], 1'b0} + 12'(bcol[2]);
    gx_neg = 12'(bw_r[0][0]) + {3'b0, bw_r[1][0], 1'b0} + 12'(bw_r[2][0]);
    gy_pos = 12'(bw_r[2][0]) + {3'b0, bw_r[2][1], 1'b0} + 12'(bcol[2]);
    gy_neg = 12'(bw_r[0][0]) + {3'b0, bw_r[0][1], 1'b0} + 12'(bcol[0]);
    agx = (gx_pos >= gx_neg) ? 10'(gx_pos - gx_neg) : 10'(gx_neg - gx_pos);
    agy = (gy_pos >= gy_neg) ? 10'(gy_pos - gy_neg) : 10'(gy_neg - gy_pos);
    mag = 11'(agx) + 11'(agy);
    mag_clamp = (mag > 11'(PIX_MAX)) ? PIX_MAX : mag[7:0];
  end

  always_ff @(posedge clk) begin
    blur_rd_r <= blur_mem[s2_x_r];
    if (s3_v_r) begin
      blur_mem[s3_x_r] <= {bcol[1], s3_b_r};
      for (int k = 0; k < 3; k++) begin
        bw_r[k][0] <= bw_r[k][1];
        bw_r[k][1] <= bcol[k];
      end
    end
  end

  // Stage 4: threshold and tally
  logic               s4_v_r, s4_cnt_r, s4_last_r;
  logic [7:0]         s4_mag_r;
  logic               hit, result_fire;
  logic [TALLY_W-1:0] tally_inc;

  assign hit         = s4_v_r && s4_cnt_r && (s4_mag_r > edge_level_r);
  assign tally_inc   = (hit && tally_r != TALLY_MAX) ? tally_r + 17'd1 : tally_r;
  assign result_fire = s4_v_r && s4_last_r;

  // Register writes wait for an empty pipeline so no late pixel lands in the new frame
  assign cfg_ready = (state_r == ST_RUN)
                   && !(s1_v_r || e2_pend_r || s2_v_r || s3_v_r || s4_v_r);

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      s1_g_r       <= luma_g;
      s1_c_r       <= col_r;
      s1_rge1_r    <= (row_r != '0);
      s1_q0_r      <= (row_r == ROW_W'(1));
      s1_qge2_r    <= (row_r >= ROW_W'(3));
      s1_lastcol_r <= last_col;
      s1_last_r    <= 1'b0;
    end else if (state_r == ST_FLUSH) begin
      s1_c_r    <= fx_r;
      s1_last_r <= fx_last;
    end

    e2_x_r    <= s1_c_r;
    e2_val_r  <= l_new;
    e2_qge2_r <= s1_qge2_r;

    if (e1) begin
      s2_x_r      <= s1_c_r - ColW'(1);
      s2_border_r <= border1;
      s2_val_r    <= lw_r[1][1];
      s2_sum_r    <= sum9;
      s2_qge2_r   <= s1_qge2_r;
      s2_last_r   <= 1'b0;
    end else if (e2_pend_r) begin
      s2_x_r      <= e2_x_r;
      s2_border_r <= 1'b1;
      s2_val_r    <= e2_val_r;
      s2_sum_r    <= '0;
      s2_qge2_r   <= e2_qge2_r;
      s2_last_r   <= 1'b0;
    end else begin
      // bottom row read back from the luma store
      s2_x_r      <= s1_c_r;
      s2_border_r <= 1'b1;
      s2_val_r    <= l_new;
      s2_sum_r    <= '0;
      s2_qge2_r   <= 1'b1;
      s2_last_r   <= s1_last_r;
    end

    s3_x_r    <= s2_x_r;
    s3_b_r    <= blur_b;
    s3_qge2_r <= s2_qge2_r;
    s3_last_r <= s2_last_r;

    s4_mag_r  <= mag_clamp;
    s4_cnt_r  <= s3_qge2_r && (s3_x_r >= ColW'(2));
    s4_last_r <= s3_last_r;
  end

  // Control, config and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_RUN;
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      edge_level_r   <= LEVEL_RST;
      defect_limit_r <= LIMIT_RST;
      err_r          <= frame_check(WIDTH_RST, HEIGHT_RST, FIELD_W'(MAX_WIDTH));
      col_r          <= '0;
      row_r          <= '0;
      fx_r           <= '0;
      tally_r        <= '0;
      s1_v_r         <= 1'b0;
      s1_fl_r        <= 1'b0;
      e2_pend_r      <= 1'b0;
      s2_v_r         <= 1'b0;
      s3_v_r         <= 1'b0;
      s4_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      out_data_r     <= '0;
    end else begin
      frame_width_r  <= width_nxt;
      frame_height_r <= height_nxt;
      edge_level_r   <= level_nxt;
      defect_limit_r <= limit_nxt;
      err_r          <= err_nxt;

      s1_v_r    <= pix_fire;
      s1_fl_r   <= (state_r == ST_FLUSH);
      e2_pend_r <= s1_v_r && s1_rge1_r && s1_lastcol_r;
      s2_v_r    <= e1 || e2_pend_r || s1_fl_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;

      if (s4_v_r) begin
        tally_r <= result_fire ? '0 : tally_inc;
      end

      case (state_r)
        ST_RUN: begin
          if (pix_fire) begin
            if (last_col) begin
              col_r <= '0;
              row_r <= last_row ? '0 : row_r + ROW_W'(1);
            end else begin
              col_r <= col_r + ColW'(1);
            end
            if (frame_done) begin
              state_r <= ST_GAP;
            end
          end
        end
        ST_GAP: begin
          // lets the right border pixel of the last row clear stage 2
          fx_r    <= '0;
          state_r <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (fx_last) begin
            state_r <= ST_DRAIN;
          end else begin
            fx_r <= fx_r + ColW'(1);
          end
        end
        ST_DRAIN: begin
          if (result_fire) begin
            state_r <= ST_RUN;
          end
        end
        default: state_r <= ST_RUN;
      endcase

      if (cfg_fire) begin
        col_r   <= '0;
        row_r   <= '0;
        tally_r <= '0;
      end

      if (result_fire) begin
        out_valid_r             <= 1'b1;
        out_data_r.verdict      <= (tally_inc > defect_limit_r) ? VERDICT_FAIL : VERDICT_PASS;
        out_data_r.defect_total <= tally_inc;
      end else if (err_fire) begin
        out_valid_r             <= 1'b1;
        out_data_r.verdict      <= err_r;
        out_data_r.defect_total <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({e1, e2_pend_r, s1_fl_r}) <= 1)
    else $error("two blurred pixels offered to stage 2 in one cycle");

  a_luma_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_v_r && (pix_fire || state_r == ST_FLUSH) && luma_ra == s1_c_r))
    else $error("luma store read and written at the same column");

  a_blur_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    !(s3_v_r && s2_v_r && s2_x_r == s3_x_r))
    else $error("blur store read and written at the same column");

  a_result_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    result_fire |-> (state_r == ST_DRAIN) && !out_valid_r)
    else $error("frame result outside drain or onto a full output register");

endmodule
`default_nettype wire
